// ===== sv/dotted_version_rank_top_assert.svh =====
// Assertion macros shared by the modules of the version rank block.
`ifndef DOTTED_VERSION_RANK_TOP_ASSERT_SVH
`define DOTTED_VERSION_RANK_TOP_ASSERT_SVH

`ifndef SYNTH
`define DVR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DVR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DVR_ASSERT(label, prop, msg)
`define DVR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== sv/dvr_pkg.sv =====
package dvr_pkg;

	localparam int unsigned PART_W = 10;
	localparam int unsigned RANK_W = 31;
	localparam int unsigned PROD_W = 14;

	localparam logic [PROD_W-1:0] PART_LIMIT = 14'd999;
	localparam logic [PROD_W-1:0] DIGIT_BASE = 14'd10;
	localparam logic [RANK_W-1:0] RANK_ERROR = 31'h7fffffff;
	localparam logic [RANK_W-1:0] MAJOR_SCALE = 31'd1000000;
	localparam logic [RANK_W-1:0] MINOR_SCALE = 31'd1000;
	localparam int unsigned CUT_DOTS = 3;

	typedef logic [PART_W-1:0] part_t;

	typedef struct packed {
		logic  malformed;
		part_t major;
		part_t minor;
		part_t patch;
	} parts_t;

endpackage

// ===== sv/dvr_in_if.sv =====
interface dvr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       no_char;
	logic       last;

	modport source (output valid, output ch, output no_char, output last, input ready);
	modport sink (input valid, input ch, input no_char, input last, output ready);
endinterface

// ===== sv/dvr_out_if.sv =====
interface dvr_out_if;
	logic                            valid;
	logic                            ready;
	logic [dvr_pkg::RANK_W-1:0]      rank;
	logic                            malformed;

	modport source (output valid, output rank, output malformed, input ready);
	modport sink (input valid, input rank, input malformed, output ready);
endinterface

// ===== sv/dvr_parse.sv =====
`include "dotted_version_rank_top_assert.svh"

module dvr_parse (
	input  logic            clk,
	input  logic            arst_n,
	dvr_in_if.sink          in,
	output dvr_pkg::parts_t res_s2,
	output logic            res_valid_s2,
	input  logic            res_ready
);

	localparam logic [7:0] CH_DOT  = 8'h2e;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	logic [7:0] ch_s1;
	logic       no_char_s1;
	logic       last_s1;
	logic       valid_s1;

	dvr_pkg::part_t major_q, minor_q, patch_q;
	logic [1:0]     part_index_q;
	logic           seen_digit_q;
	logic           error_seen_q;
	logic [1:0]     dot_count_q;
	logic           cut_off_q;

	dvr_pkg::part_t major_d, minor_d, patch_d, cur_part;
	logic [1:0]     part_index_d;
	logic           seen_digit_d;
	logic           error_seen_d;
	logic [1:0]     dot_count_d;
	logic           cut_off_d;
	logic [dvr_pkg::PROD_W-1:0] prod;
	logic           is_dot;
	logic           is_digit;

	logic s2_free;
	logic s1_go;
	logic in_take;

	assign s2_free = !res_valid_s2 || res_ready;
	assign s1_go = valid_s1 && (!last_s1 || s2_free);
	assign in.ready = !valid_s1 || s1_go;
	assign in_take = in.valid && in.ready;

	assign is_dot = ch_s1 == CH_DOT;
	assign is_digit = ch_s1 >= CH_ZERO && ch_s1 <= CH_NINE;

	always_comb begin
		case (part_index_q)
			2'd0: cur_part = major_q;
			2'd1: cur_part = minor_q;
			default: cur_part = patch_q;
		endcase
		prod = dvr_pkg::PROD_W'(cur_part) * dvr_pkg::DIGIT_BASE
			+ dvr_pkg::PROD_W'(ch_s1 - CH_ZERO);
	end

	always_comb begin
		major_d = major_q;
		minor_d = minor_q;
		patch_d = patch_q;
		part_index_d = part_index_q;
		seen_digit_d = seen_digit_q;
		error_seen_d = error_seen_q;
		dot_count_d = dot_count_q;
		cut_off_d = cut_off_q;
		if (!cut_off_q && !no_char_s1) begin
			if (is_dot) begin
				dot_count_d = dot_count_q + 2'd1;
				if (dot_count_q >= 2'(dvr_pkg::CUT_DOTS - 1)) begin
					cut_off_d = 1'b1;
				end else if (!error_seen_q) begin
					if (!seen_digit_q || part_index_q == 2'd2) begin
						error_seen_d = 1'b1;
					end else begin
						part_index_d = part_index_q + 2'd1;
						seen_digit_d = 1'b0;
					end
				end
			end else if (is_digit) begin
				if (!error_seen_q) begin
					if (prod > dvr_pkg::PART_LIMIT) begin
						error_seen_d = 1'b1;
					end else begin
						case (part_index_q)
							2'd0: major_d = prod[dvr_pkg::PART_W-1:0];
							2'd1: minor_d = prod[dvr_pkg::PART_W-1:0];
							default: patch_d = prod[dvr_pkg::PART_W-1:0];
						endcase
						seen_digit_d = 1'b1;
					end
				end
			end else begin
				error_seen_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ch_s1 <= in.ch;
			no_char_s1 <= in.no_char;
			last_s1 <= in.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q <= '0;
			minor_q <= '0;
			patch_q <= '0;
			part_index_q <= '0;
			seen_digit_q <= 1'b0;
			error_seen_q <= 1'b0;
			dot_count_q <= '0;
			cut_off_q <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				major_q <= '0;
				minor_q <= '0;
				patch_q <= '0;
				part_index_q <= '0;
				seen_digit_q <= 1'b0;
				error_seen_q <= 1'b0;
				dot_count_q <= '0;
				cut_off_q <= 1'b0;
			end else begin
				major_q <= major_d;
				minor_q <= minor_d;
				patch_q <= patch_d;
				part_index_q <= part_index_d;
				seen_digit_q <= seen_digit_d;
				error_seen_q <= error_seen_d;
				dot_count_q <= dot_count_d;
				cut_off_q <= cut_off_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (s1_go && last_s1) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			res_s2.malformed <= error_seen_d || !seen_digit_d;
			res_s2.major <= major_d;
			res_s2.minor <= minor_d;
			res_s2.patch <= patch_d;
		end
	end

	`DVR_ASSERT(a_clear_after_last, s1_go && last_s1 |=> part_index_q == 2'd0 && !seen_digit_q && !error_seen_q && !cut_off_q, "state not cleared after last word")
	`DVR_ASSERT_ALWAYS(a_part_index_range, part_index_q != 2'd3, "part index out of range")
	`DVR_ASSERT(a_s2_hold, res_valid_s2 && !res_ready |=> res_valid_s2 && $stable(res_s2), "pending result lost while stalled")
	`DVR_ASSERT(a_no_word_while_stalled, valid_s1 && last_s1 && !s2_free |-> !in.ready, "input taken over a blocked last word")

endmodule

// ===== sv/dvr_rank.sv =====
`include "dotted_version_rank_top_assert.svh"

module dvr_rank (
	input  logic            clk,
	input  logic            arst_n,
	input  dvr_pkg::parts_t res_s2,
	input  logic            res_valid_s2,
	output logic            res_ready,
	dvr_out_if.source       out
);

	logic                       out_valid_q;
	logic [dvr_pkg::RANK_W-1:0] rank_q;
	logic                       malformed_q;
	logic [dvr_pkg::RANK_W-1:0] sum;
	logic                       take;

	assign res_ready = !out_valid_q || out.ready;
	assign take = res_valid_s2 && res_ready;

	assign sum = dvr_pkg::RANK_W'(res_s2.major) * dvr_pkg::MAJOR_SCALE
		+ dvr_pkg::RANK_W'(res_s2.minor) * dvr_pkg::MINOR_SCALE
		+ dvr_pkg::RANK_W'(res_s2.patch);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			malformed_q <= res_s2.malformed;
			rank_q <= res_s2.malformed ? dvr_pkg::RANK_ERROR : sum;
		end
	end

	assign out.valid = out_valid_q;
	assign out.rank = rank_q;
	assign out.malformed = malformed_q;

	`DVR_ASSERT(a_error_rank, out_valid_q && malformed_q |-> rank_q == dvr_pkg::RANK_ERROR, "malformed word without error rank")
	`DVR_ASSERT(a_good_rank, out_valid_q && !malformed_q |-> rank_q < 31'd1000000000, "well formed rank out of range")

endmodule

// ===== sv/dotted_version_rank_top.sv =====
// Dotted version rank: takes a version string one character per input word
// (ch, with last on the final word; an empty string is one word with no_char
// and last set) and returns one word per string holding
// major*1000000 + minor*1000 + patch, or 2147483647 with malformed set when
// the text is rejected. A character is accepted every cycle unless the input
// register holds a last character that the full parse result register
// cannot yet take. The input register captures each accepted character, the
// parse result register then the parsed parts, and the rank output register the rank.
// The output register lets input continue while a result waits to be taken.
module dotted_version_rank_top (
	input logic        clk,
	input logic        arst_n,
	dvr_in_if.sink     in,
	dvr_out_if.source  out
);

	dvr_pkg::parts_t res_s2;
	logic            res_valid_s2;
	logic            res_ready;

	dvr_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.in           (in),
		.res_s2       (res_s2),
		.res_valid_s2 (res_valid_s2),
		.res_ready    (res_ready)
	);

	dvr_rank u_rank (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_s2       (res_s2),
		.res_valid_s2 (res_valid_s2),
		.res_ready    (res_ready),
		.out          (out)
	);

endmodule
